// ===== design/wcmg_pkg.sv =====
// ----------------------------------------------------------------------------
// wcmg_pkg: word clock mask generator shared definitions
// Letter grid geometry, time constants and the word lookup tables that turn
// a time of day into the lit-pixel mask of the 256-letter grid.
// ----------------------------------------------------------------------------
package wcmg_pkg;

    localparam int PIXEL_COUNT = 256;
    localparam int WORD_W      = 64;
    localparam int HOUR_W      = 5;
    localparam int MINUTE_W    = 6;

    // Time of day limits and period boundaries
    localparam logic [HOUR_W-1:0]   HOURS_PER_DAY    = 5'd24;
    localparam logic [HOUR_W-1:0]   LAST_HOUR        = 5'd23;
    localparam logic [HOUR_W-1:0]   HOURS_PER_HALF   = 5'd12;
    localparam logic [HOUR_W-1:0]   MORNING_START    = 5'd5;
    localparam logic [HOUR_W-1:0]   AFTERNOON_START  = 5'd12;
    localparam logic [HOUR_W-1:0]   EVENING_START    = 5'd17;
    localparam logic [HOUR_W-1:0]   NIGHT_START      = 5'd21;
    localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = 6'd60;
    localparam logic [MINUTE_W-1:0] HALF_MINUTE      = 6'd30;
    localparam logic [MINUTE_W-1:0] TWENTY_MINUTE    = 6'd20;
    localparam logic [MINUTE_W-1:0] TEN_MINUTE       = 6'd10;

    // Grid positions of the fixed words (first letter)
    localparam int POS_IT       = 0;
    localparam int POS_IS       = 3;
    localparam int POS_TWENTY   = 6;
    localparam int POS_HALF     = 112;
    localparam int POS_A        = 113;
    localparam int POS_QUARTER  = 118;
    localparam int POS_TO       = 126;
    localparam int POS_PAST     = 128;
    localparam int POS_MIDNIGHT = 72;
    localparam int POS_AT_UPPER = 137;
    localparam int POS_AT_LOWER = 216;
    localparam int POS_NIGHT    = 219;
    localparam int POS_IN_UPPER = 55;
    localparam int POS_IN_MID   = 173;
    localparam int POS_IN_LOWER = 192;
    localparam int POS_THE      = 195;
    localparam int POS_MORNING  = 208;
    localparam int POS_AFTNOON  = 199;
    localparam int POS_EVENING  = 224;

    typedef logic [PIXEL_COUNT-1:0] t_mask;

    typedef enum logic [1:0] {
        PERIOD_NIGHT,
        PERIOD_MORNING,
        PERIOD_AFTERNOON,
        PERIOD_EVENING
    } t_period;

    // Light len letters starting at grid position lo
    function automatic t_mask span(input int lo, input int len);
        t_mask m;
        m = '0;
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            m[i] = (i >= lo) && (i < lo + len);
        end
        return m;
    endfunction

    // Hour word (0 reads as TWELVE); late selects the copy below PAST / TO.
    // Early copies double as the unit words of the minute phrase.
    function automatic t_mask hour_mask(input logic [3:0] h12, input logic late);
        t_mask m;
        m = '0;
        if (late) begin
            unique case (h12)
                4'd1:    m = span(133, 3);
                4'd2:    m = span(138, 3);
                4'd3:    m = span(180, 5);
                4'd4:    m = span(151, 4);
                4'd5:    m = span(156, 4);
                4'd6:    m = span(141, 3);
                4'd7:    m = span(160, 5);
                4'd8:    m = span(166, 5);
                4'd9:    m = span(172, 4);
                4'd10:   m = span(170, 3);
                4'd11:   m = span(186, 6);
                default: m = span(144, 6);
            endcase
        end else begin
            unique case (h12)
                4'd1:    m = span(13, 3);
                4'd2:    m = span(16, 3);
                4'd3:    m = span(48, 5);
                4'd4:    m = span(44, 4);
                4'd5:    m = span(32, 4);
                4'd6:    m = span(80, 3);
                4'd7:    m = span(96, 5);
                4'd8:    m = span(88, 5);
                4'd9:    m = span(54, 4);
                4'd10:   m = span(20, 3);
                4'd11:   m = span(37, 6);
                default: m = span(106, 6);
            endcase
        end
        return m;
    endfunction

    // Unit word of the minute phrase; zero lights nothing
    function automatic t_mask unit_mask(input logic [3:0] u);
        t_mask m;
        m = '0;
        if (u != 4'd0) begin
            m = hour_mask(u, 1'b0);
        end
        return m;
    endfunction

    // Minutes ten to nineteen, quarter as the pair A QUARTER
    function automatic t_mask teen_mask(input logic [3:0] t);
        t_mask m;
        m = '0;
        unique case (t)
            4'd0:    m = span(20, 3);
            4'd1:    m = span(37, 6);
            4'd2:    m = span(106, 6);
            4'd3:    m = span(24, 8);
            4'd4:    m = span(64, 8);
            4'd5:    m = span(POS_A, 1) | span(POS_QUARTER, 7);
            4'd6:    m = span(80, 7);
            4'd7:    m = span(96, 9);
            4'd8:    m = span(88, 8);
            4'd9:    m = span(54, 8);
            default: m = '0;
        endcase
        return m;
    endfunction

    // Minute phrase for a folded minute of 1 to 30
    function automatic t_mask minute_mask(input logic [MINUTE_W-1:0] mf);
        t_mask m;
        m = '0;
        if (mf == HALF_MINUTE) begin
            m = span(POS_HALF, 4);
        end else if (mf >= TWENTY_MINUTE) begin
            m = span(POS_TWENTY, 6) | unit_mask(4'(mf - TWENTY_MINUTE));
        end else if (mf >= TEN_MINUTE) begin
            m = teen_mask(4'(mf - TEN_MINUTE));
        end else begin
            m = unit_mask(mf[3:0]);
        end
        return m;
    endfunction

    // Period phrase; where it lands depends on where the hour word ended
    function automatic t_mask period_mask(input t_period p, input logic [3:0] h12,
                                          input logic late);
        t_mask m;
        int    pos;
        m   = '0;
        pos = POS_IN_MID;
        if (p == PERIOD_NIGHT) begin
            pos = (late && (h12 != 4'd1)) ? POS_AT_LOWER : POS_AT_UPPER;
            m   = span(pos, 2) | span(POS_NIGHT, 5);
        end else begin
            if (late) begin
                case (h12) inside
                    4'd3, 4'd9, 4'd11: pos = POS_IN_LOWER;
                    default:           pos = POS_IN_MID;
                endcase
            end else begin
                case (h12) inside
                    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd10, 4'd11: pos = POS_IN_UPPER;
                    default:                                    pos = POS_IN_MID;
                endcase
            end
            m = span(pos, 2) | span(POS_THE, 3);
            unique case (p)
                PERIOD_MORNING:   m = m | span(POS_MORNING, 7);
                PERIOD_AFTERNOON: m = m | span(POS_AFTNOON, 9);
                PERIOD_EVENING:   m = m | span(POS_EVENING, 7);
                default:          m = m;
            endcase
        end
        return m;
    endfunction

endpackage

// ===== design/word_clock_mask_generator_top.sv =====
// ----------------------------------------------------------------------------
// word_clock_mask_generator_top: time of day to word clock pixel mask
// Lights the letters of the phrase for one hour and minute on a fixed
// 256-letter grid and returns the mask as four 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_hour_of_day (0..23) and
//   i_minute_of_hour (0..59). An item is taken at a clock edge with i_valid
//   high and o_stall low. Hours 24..31 wrap by a day, minutes 60..63 read
//   as the full hour.
//   Output channel: o_valid / i_stall with o_mask_word0..3; bit i of word k
//   is pixel 64*k+i. A result moves at an edge with o_valid high and
//   i_stall low.
//   Path: the input register loads at the accepting edge and the result
//   register loads from it when not stalled; o_valid is the result register.
//   Throughput: one item per cycle while the receiver does not stall; the
//   phrase decode is a set of constant word tables between the two registers.
//   Stall: while the receiver stalls, the result register holds and the
//   input register can still take one more item; o_stall rises only when
//   both registers are full and the receiver stalls.
//   Reset: i_rst_n low at a clock edge empties both registers; no result
//   is pending afterwards.
// ----------------------------------------------------------------------------
module word_clock_mask_generator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [wcmg_pkg::HOUR_W-1:0]          i_hour_of_day,
    input  logic [wcmg_pkg::MINUTE_W-1:0]        i_minute_of_hour,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [wcmg_pkg::WORD_W-1:0]          o_mask_word0,
    output logic [wcmg_pkg::WORD_W-1:0]          o_mask_word1,
    output logic [wcmg_pkg::WORD_W-1:0]          o_mask_word2,
    output logic [wcmg_pkg::WORD_W-1:0]          o_mask_word3
);

    logic                            r_in_valid;
    logic [wcmg_pkg::HOUR_W-1:0]     r_hour;
    logic [wcmg_pkg::MINUTE_W-1:0]   r_minute;
    logic                            r_out_valid;
    wcmg_pkg::t_mask                 r_mask;

    logic                            out_load;
    logic                            in_load;
    logic [wcmg_pkg::HOUR_W-1:0]     hr;
    logic [wcmg_pkg::HOUR_W-1:0]     hr_adj;
    logic [3:0]                      h12;
    logic [wcmg_pkg::MINUTE_W-1:0]   mn;
    logic [wcmg_pkg::MINUTE_W-1:0]   mf;
    logic                            is_to;
    logic                            late;
    logic                            midnight;
    wcmg_pkg::t_period               period;
    wcmg_pkg::t_mask                 n_mask;

    // Handshake: each register loads when empty or when its item moves on
    assign out_load = !r_out_valid || !i_stall;
    assign in_load  = !r_in_valid || out_load;
    assign o_stall  = !in_load;
    assign o_valid  = r_out_valid;

    // Capture the input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
        if (in_load && i_valid) begin
            r_hour   <= i_hour_of_day;
            r_minute <= i_minute_of_hour;
        end
    end

    // Normalize the time and fold minutes past the half hour
    always_comb begin
        hr       = (r_hour >= wcmg_pkg::HOURS_PER_DAY) ?
                   5'(r_hour - wcmg_pkg::HOURS_PER_DAY) : r_hour;
        mn       = (r_minute >= wcmg_pkg::MINUTES_PER_HOUR) ? '0 : r_minute;
        midnight = (hr == '0) && (mn == '0);
        late     = (mn != '0);
        is_to    = (mn > wcmg_pkg::HALF_MINUTE);
        mf       = is_to ? 6'(wcmg_pkg::MINUTES_PER_HOUR - mn) : mn;
        if (is_to) begin
            hr_adj = (hr == wcmg_pkg::LAST_HOUR) ? '0 : 5'(hr + 5'd1);
        end else begin
            hr_adj = hr;
        end
        h12 = (hr_adj >= wcmg_pkg::HOURS_PER_HALF) ?
              4'(hr_adj - wcmg_pkg::HOURS_PER_HALF) : hr_adj[3:0];
        if (hr_adj < wcmg_pkg::MORNING_START) begin
            period = wcmg_pkg::PERIOD_NIGHT;
        end else if (hr_adj < wcmg_pkg::AFTERNOON_START) begin
            period = wcmg_pkg::PERIOD_MORNING;
        end else if (hr_adj < wcmg_pkg::EVENING_START) begin
            period = wcmg_pkg::PERIOD_AFTERNOON;
        end else if (hr_adj < wcmg_pkg::NIGHT_START) begin
            period = wcmg_pkg::PERIOD_EVENING;
        end else begin
            period = wcmg_pkg::PERIOD_NIGHT;
        end
    end

    // Assemble the phrase mask from the word tables
    always_comb begin
        n_mask = wcmg_pkg::span(wcmg_pkg::POS_IT, 2) | wcmg_pkg::span(wcmg_pkg::POS_IS, 2);
        if (midnight) begin
            n_mask = n_mask | wcmg_pkg::span(wcmg_pkg::POS_MIDNIGHT, 8);
        end else begin
            if (late) begin
                n_mask = n_mask | wcmg_pkg::minute_mask(mf);
                n_mask = n_mask | (is_to ? wcmg_pkg::span(wcmg_pkg::POS_TO, 2)
                                         : wcmg_pkg::span(wcmg_pkg::POS_PAST, 4));
            end
            n_mask = n_mask | wcmg_pkg::hour_mask(h12, late)
                            | wcmg_pkg::period_mask(period, h12, late);
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
        if (out_load && r_in_valid) begin
            r_mask <= n_mask;
        end
    end

    assign o_mask_word0 = r_mask[0*wcmg_pkg::WORD_W +: wcmg_pkg::WORD_W];
    assign o_mask_word1 = r_mask[1*wcmg_pkg::WORD_W +: wcmg_pkg::WORD_W];
    assign o_mask_word2 = r_mask[2*wcmg_pkg::WORD_W +: wcmg_pkg::WORD_W];
    assign o_mask_word3 = r_mask[3*wcmg_pkg::WORD_W +: wcmg_pkg::WORD_W];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: word clock mask generator testbench
// Drives hour/minute items through the valid/stall input channel with bursty
// traffic, predicts each 256-pixel mask by spelling the time as a phrase and
// searching its words in the letter grid, and checks the four mask words of
// every result in order while the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------

// Phrase predictor plus the queue of masks still owed by the block
class mask_scoreboard;

    wcmg_pkg::t_mask expected_masks[$];
    int unsigned     error_count;
    string           letter_grid;

    // Scan state of one phrase search
    wcmg_pkg::t_mask lit;
    int              scan_pos;
    bit              scan_halted;

    function new();
        error_count   = 0;
        letter_grid   = {"ITLISOTWENTYRONETWOETENMTHIRTEENFIVEMELEVENIFOURTHREEPNINETEENSU",
                         "FOURTEENMIDNIGHTSIXTEENDEIGHTEENSEVENTEENOTWELVEHALFELQUARTEROTO",
                         "PASTRONESATWOSIXTWELVETFOURAFIVESEVENMEIGHTENINETENTTHREECELEVEN",
                         "INOTHENAFTERNOONMORNINGSATENIGHTEVENINGCANDTCOLDCOOLETWARMURAHOT"};
    endfunction

    function string number_word(int n);
        case (n)
            1:       return "ONE";
            2:       return "TWO";
            3:       return "THREE";
            4:       return "FOUR";
            5:       return "FIVE";
            6:       return "SIX";
            7:       return "SEVEN";
            8:       return "EIGHT";
            9:       return "NINE";
            10:      return "TEN";
            11:      return "ELEVEN";
            12:      return "TWELVE";
            default: return "";
        endcase
    endfunction

    function string teen_word(int t);
        case (t)
            3:       return "THIRTEEN";
            4:       return "FOURTEEN";
            5:       return "A QUARTER";
            6:       return "SIXTEEN";
            7:       return "SEVENTEEN";
            8:       return "EIGHTEEN";
            9:       return "NINETEEN";
            default: return number_word(t + 10);
        endcase
    endfunction

    // Find one word at or past the scan position; a miss halts the search
    function void light_word(string w);
        int n;
        n = w.len();
        if (scan_halted || n == 0) return;
        for (int p = scan_pos; p + n <= wcmg_pkg::PIXEL_COUNT; p++) begin
            if (letter_grid.substr(p, p + n - 1) == w) begin
                for (int j = 0; j < n; j++) lit[p + j] = 1'b1;
                scan_pos = p + n;
                return;
            end
        end
        scan_halted = 1'b1;
    endfunction

    function void light_phrase(string ph);
        int start;
        start = 0;
        for (int i = 0; i <= ph.len(); i++) begin
            if (i == ph.len() || ph[i] == " ") begin
                if (i > start) light_word(ph.substr(start, i - 1));
                start = i + 1;
            end
        end
    endfunction

    // Spell the time and light its words in order
    function wcmg_pkg::t_mask predict_mask(logic [4:0] hour_in, logic [5:0] minute_in);
        int                hr;
        int                mn;
        bit                to_next;
        wcmg_pkg::t_period period;
        hr          = hour_in;
        mn          = minute_in;
        lit         = '0;
        scan_pos    = 0;
        scan_halted = 1'b0;
        // Wrap out-of-range hours by a day, read stray minutes as the full hour
        if (hr >= wcmg_pkg::HOURS_PER_DAY) hr -= wcmg_pkg::HOURS_PER_DAY;
        if (mn >= wcmg_pkg::MINUTES_PER_HOUR) mn = 0;
        light_phrase("IT IS");
        if (hr == 0 && mn == 0) begin
            light_phrase("MIDNIGHT");
            return lit;
        end
        if (mn != 0) begin
            to_next = 1'b0;
            if (mn > wcmg_pkg::HALF_MINUTE) begin
                mn      = wcmg_pkg::MINUTES_PER_HOUR - mn;
                to_next = 1'b1;
            end
            if (mn == wcmg_pkg::HALF_MINUTE) begin
                light_phrase("HALF");
            end else if (mn >= wcmg_pkg::TWENTY_MINUTE) begin
                light_phrase("TWENTY");
                if (mn % 10 != 0) light_phrase(number_word(mn % 10));
            end else if (mn >= wcmg_pkg::TEN_MINUTE) begin
                light_phrase(teen_word(mn - wcmg_pkg::TEN_MINUTE));
            end else begin
                light_phrase(number_word(mn));
            end
            // TO advances the hour, wrapping the day
            if (to_next) begin
                light_phrase("TO");
                hr = (hr + 1) % wcmg_pkg::HOURS_PER_DAY;
            end else begin
                light_phrase("PAST");
            end
        end
        light_phrase(number_word((hr % 12 == 0) ? 12 : hr % 12));
        if (hr < wcmg_pkg::MORNING_START)        period = wcmg_pkg::PERIOD_NIGHT;
        else if (hr < wcmg_pkg::AFTERNOON_START) period = wcmg_pkg::PERIOD_MORNING;
        else if (hr < wcmg_pkg::EVENING_START)   period = wcmg_pkg::PERIOD_AFTERNOON;
        else if (hr < wcmg_pkg::NIGHT_START)     period = wcmg_pkg::PERIOD_EVENING;
        else                                     period = wcmg_pkg::PERIOD_NIGHT;
        case (period)
            wcmg_pkg::PERIOD_MORNING:   light_phrase("IN THE MORNING");
            wcmg_pkg::PERIOD_AFTERNOON: light_phrase("IN THE AFTERNOON");
            wcmg_pkg::PERIOD_EVENING:   light_phrase("IN THE EVENING");
            default:                    light_phrase("AT NIGHT");
        endcase
        return lit;
    endfunction

    function void note_item(logic [4:0] hour_in, logic [5:0] minute_in);
        expected_masks.push_back(predict_mask(hour_in, minute_in));
    endfunction

    function int pending();
        return expected_masks.size();
    endfunction

    function void flag(string msg);
        error_count++;
        $error("%s", msg);
    endfunction

    function void compare_word(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
            flag($sformatf("%s: expected %016h, got %016h", field, want, got));
    endfunction

    function void check_mask(logic [63:0] w0, logic [63:0] w1,
                             logic [63:0] w2, logic [63:0] w3);
        wcmg_pkg::t_mask want;
        if (expected_masks.size() == 0) begin
            flag("mask result arrived with no item outstanding");
            return;
        end
        want = expected_masks.pop_front();
        compare_word("mask_word0", want[63:0],    w0);
        compare_word("mask_word1", want[127:64],  w1);
        compare_word("mask_word2", want[191:128], w2);
        compare_word("mask_word3", want[255:192], w3);
    endfunction

    function void flush_check();
        if (expected_masks.size() != 0)
            flag($sformatf("%0d mask results never arrived", expected_masks.size()));
    endfunction

endclass

module tb;

    localparam int RANDOM_ITEMS = 1050;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DIRECTED_N   = 25;

    // Extremes, midnight, wraps, quarter/half/twenty, period boundaries
    localparam logic [4:0] DIR_HOURS [DIRECTED_N] = '{
        5'd0,  5'd24, 5'd31, 5'd0,  5'd23, 5'd23, 5'd12, 5'd4,  5'd11, 5'd16,
        5'd17, 5'd20, 5'd21, 5'd5,  5'd4,  5'd11, 5'd16, 5'd20, 5'd13, 5'd7,
        5'd9,  5'd31, 5'd0,  5'd12, 5'd6
    };
    localparam logic [5:0] DIR_MINUTES [DIRECTED_N] = '{
        6'd0,  6'd0,  6'd63, 6'd60, 6'd59, 6'd31, 6'd30, 6'd45, 6'd15, 6'd20,
        6'd21, 6'd29, 6'd10, 6'd1,  6'd59, 6'd40, 6'd31, 6'd55, 6'd12, 6'd11,
        6'd9,  6'd0,  6'd1,  6'd0,  6'd14
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BLOCKS
    } t_stall_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [4:0]  i_hour_of_day;
    logic [5:0]  i_minute_of_hour;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_mask_word0;
    logic [63:0] o_mask_word1;
    logic [63:0] o_mask_word2;
    logic [63:0] o_mask_word3;

    mask_scoreboard board;
    int             burst_left;
    int             idle_cycles = 0;
    int             stall_run = 0;
    t_stall_mode    stall_mode = STALL_NONE;

    word_clock_mask_generator_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_hour_of_day    (i_hour_of_day),
        .i_minute_of_hour (i_minute_of_hour),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mask_word0     (o_mask_word0),
        .o_mask_word1     (o_mask_word1),
        .o_mask_word2     (o_mask_word2),
        .o_mask_word3     (o_mask_word3)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: switch between stall patterns after each random run
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_run  = $urandom_range(20, 150);
        end
        stall_run--;
        case (stall_mode)
            STALL_LIGHT:  i_stall = ($urandom_range(0, 9) < 2);
            STALL_HEAVY:  i_stall = ($urandom_range(0, 9) < 7);
            STALL_BLOCKS: i_stall = ((stall_run % 8) < 5);
            default:      i_stall = 1'b0;
        endcase
    end

    // Note accepted items, check accepted masks, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) board.note_item(i_hour_of_day, i_minute_of_hour);
            if (o_valid && !i_stall)
                board.check_mask(o_mask_word0, o_mask_word1, o_mask_word2, o_mask_word3);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("word_clock_mask_generator_top verification failed");
                $finish;
            end
        end
    end

    // Offer one item, opening a new burst after a random gap when due
    task automatic send_item(input logic [4:0] hour, input logic [5:0] minute);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid          = 1'b1;
        i_hour_of_day    = hour;
        i_minute_of_hour = minute;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every owed mask has come back
    task automatic drain_results();
        i_valid    = 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [4:0] hour;
        logic [5:0] minute;
        int         pick;
        board            = new();
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_hour_of_day    = '0;
        i_minute_of_hour = '0;
        burst_left       = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners
        for (int k = 0; k < DIRECTED_N; k++) send_item(DIR_HOURS[k], DIR_MINUTES[k]);
        drain_results();

        // Random times, mostly in range, some stray hours and minutes
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) drain_results();
            pick   = $urandom_range(0, 9);
            hour   = (pick == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
            minute = (pick == 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
            send_item(hour, minute);
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        board.flush_check();
        if (board.error_count == 0) begin
            $display("word_clock_mask_generator_top verification clean");
        end else begin
            $display("word_clock_mask_generator_top verification failed");
        end
        $finish;
    end

endmodule
